### src/rlrb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the receive line ring buffer.
// No dependencies; used by rlrb_seq and rx_line_ring_buffer.
package rlrb_pkg;

  // Operation codes carried in the request kind.
  localparam logic OP_PUSH      = 1'b0;
  localparam logic OP_TAKE_LINE = 1'b1;

  // Line terminator searched for by a take-line request.
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;

  // One result as handed from the sequencer to the output register.
  typedef struct packed {
    logic       byte_stored;
    logic       line_found;
    logic [7:0] line_byte;
    logic       last_of_run;
  } result_t;

endpackage

### src/rlrb_store.sv
`timescale 1ns / 1ps
// Byte storage of the ring: one write port, one read port, registered read data.
// No dependencies.
module rlrb_store #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [7:0]               rd_data
);

  logic [7:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/rlrb_seq.sv
`timescale 1ns / 1ps
// Request sequencer: ring pointers, push handling, newline scan and line emission.
// Depends on rlrb_pkg; drives the rlrb_store memory ports.
module rlrb_seq #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_op,
  input  logic [7:0]               in_byte,
  output logic                     res_valid,
  input  logic                     res_ready,
  output rlrb_pkg::result_t        res,
  output logic                     mem_wr_en,
  output logic [$clog2(DEPTH)-1:0] mem_wr_addr,
  output logic [7:0]               mem_wr_data,
  output logic                     mem_rd_en,
  output logic [$clog2(DEPTH)-1:0] mem_rd_addr,
  input  logic [7:0]               mem_rd_data
);
  import rlrb_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_NOLINE,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

  state_t           state;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] scan_ptr;
  logic [PTR_W-1:0] emit_ptr;
  logic [PTR_W-1:0] end_ptr;
  logic             op;
  logic [7:0]       rx_byte;
  logic             full;
  logic             emit_last;

  // Pointer increment with wrap at DEPTH-1, also for non-power-of-two depths.
  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // One slot stays empty, so the ring is full when the writer would meet the reader.
  assign full      = (ptr_next(wr_ptr) == rd_ptr);
  assign emit_last = (ptr_next(emit_ptr) == end_ptr);
  assign in_ready  = (state == ST_IDLE);

  // Memory accesses. Writes happen only in the push state and reads only during
  // a take-line, so the two never touch the same entry in overlapping cycles.
  assign mem_wr_en   = (state == ST_PUSH) && res_ready && !full;
  assign mem_wr_addr = wr_ptr;
  assign mem_wr_data = rx_byte;
  assign mem_rd_en   = ((state == ST_SCAN_RD) && (scan_ptr != wr_ptr)) ||
                       (state == ST_EMIT_RD);
  assign mem_rd_addr = (state == ST_EMIT_RD) ? emit_ptr : scan_ptr;

  // Result offered to the output register.
  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    case (state)
      ST_PUSH: begin
        res_valid       = 1'b1;
        res.byte_stored = !full;
        res.last_of_run = 1'b1;
      end
      ST_NOLINE: begin
        res_valid       = 1'b1;
        res.last_of_run = 1'b1;
      end
      ST_EMIT_OUT: begin
        res_valid       = 1'b1;
        res.line_found  = 1'b1;
        res.line_byte   = mem_rd_data;
        res.last_of_run = emit_last;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // Sequencer state and pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      scan_ptr <= '0;
      emit_ptr <= '0;
      end_ptr  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            scan_ptr <= rd_ptr;
            state    <= (in_op == OP_PUSH) ? ST_PUSH : ST_SCAN_RD;
          end
        end
        ST_PUSH: begin
          if (res_ready) begin
            if (!full) begin
              wr_ptr <= ptr_next(wr_ptr);
            end
            state <= ST_IDLE;
          end
        end
        ST_SCAN_RD: begin
          // Reaching the writer means no complete line is stored.
          state <= (scan_ptr == wr_ptr) ? ST_NOLINE : ST_SCAN_CHK;
        end
        ST_SCAN_CHK: begin
          scan_ptr <= ptr_next(scan_ptr);
          if (mem_rd_data == NEWLINE_CODE) begin
            end_ptr  <= ptr_next(scan_ptr);
            emit_ptr <= rd_ptr;
            state    <= ST_EMIT_RD;
          end else begin
            state <= ST_SCAN_RD;
          end
        end
        ST_NOLINE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT_RD: begin
          state <= ST_EMIT_OUT;
        end
        ST_EMIT_OUT: begin
          if (res_ready) begin
            emit_ptr <= ptr_next(emit_ptr);
            if (emit_last) begin
              rd_ptr <= end_ptr;
              state  <= ST_IDLE;
            end else begin
              state <= ST_EMIT_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Request payload capture.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op      <= in_op;
      rx_byte <= in_byte;
    end
  end

  // The kind of the held request must match the branch taken.
  a_push_kind: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUSH) |-> (op == OP_PUSH))
    else $error("push state entered for a take-line request");

  // The final byte of an emitted line is always the terminator.
  a_line_ends_newline: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.line_found && res.last_of_run) |-> (res.line_byte == NEWLINE_CODE))
    else $error("emitted line does not end in a newline");

  // Only a stored push moves the write pointer.
  a_wr_ptr_hold: assert property (@(posedge clk) disable iff (rst)
    (state != ST_PUSH) |=> (wr_ptr == $past(wr_ptr)))
    else $error("write pointer moved outside a push");

  // Completing a line frees exactly the bytes through the newline.
  a_rd_ptr_free: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_EMIT_OUT) && res_ready && emit_last) |=> (rd_ptr == $past(end_ptr)))
    else $error("read pointer not advanced past the emitted line");

endmodule

### src/rx_line_ring_buffer.sv
`timescale 1ns / 1ps
// Receive line ring buffer: push requests store bytes, take-line requests emit
// the oldest complete line. A push result is registered from the push state and
// the next request is taken back in idle. A take-line scans each stored byte in
// a read and a check state and emits each line byte in a read and an output state,
// bound by the single read port and its registered read data; the buffer takes no
// new request until the line is out. With no newline, the scan runs to the writer
// and a single result follows. An output stall holds the sequencer in its result state.
// Reset empties the ring at once; the byte memory is not cleared.
// Depends on rlrb_pkg, rlrb_seq, rlrb_store.
module rx_line_ring_buffer #(
  parameter int DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  logic       s_axis_tuser,   // [0] operation
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] line_byte
  output logic [1:0] m_axis_tuser,   // [0] byte_stored, [1] line_found
  output logic       m_axis_tlast    // last_of_run
);
  import rlrb_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  logic             res_valid;
  logic             res_ready;
  result_t          res;
  logic             mem_wr_en;
  logic [PTR_W-1:0] mem_wr_addr;
  logic [7:0]       mem_wr_data;
  logic             mem_rd_en;
  logic [PTR_W-1:0] mem_rd_addr;
  logic [7:0]       mem_rd_data;

  rlrb_seq #(
    .DEPTH(DEPTH)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_op       (s_axis_tuser),
    .in_byte     (s_axis_tdata),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  rlrb_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Output register: takes a new result when empty or being drained.
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_axis_tdata <= res.line_byte;
      m_axis_tuser <= {res.line_found, res.byte_stored};
      m_axis_tlast <= res.last_of_run;
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for rx_line_ring_buffer: a line ring predictor scores every
// result; tasks send requests, a receiver process takes results, both with random stalls.
// Depends on rlrb_pkg and the rx_line_ring_buffer RTL.
module testbench;
  import rlrb_pkg::*;

  // Predicts the results of each accepted request from its own copy of the ring.
  class line_ring_predictor;
    int unsigned depth;
    logic [7:0] ring [0:63];
    int unsigned wr_ptr;
    int unsigned rd_ptr;
    result_t expected_results[$];
    int errors;
    int pushes;
    int takes;
    int dropped;
    int lines_taken;
    int results_seen;

    function new(int unsigned ring_depth);
      depth = ring_depth;
      wr_ptr = 0;
      rd_ptr = 0;
      errors = 0;
      pushes = 0;
      takes = 0;
      dropped = 0;
      lines_taken = 0;
      results_seen = 0;
    endfunction

    function int unsigned next_slot(int unsigned p);
      return (p + 1 >= depth) ? 0 : p + 1;
    endfunction

    function int unsigned stored_count();
      return (wr_ptr + depth - rd_ptr) % depth;
    endfunction

    // Looks for a newline from the oldest byte on; stop is the slot just past it.
    function bit find_newline(output int unsigned stop);
      int unsigned idx;
      idx = rd_ptr;
      stop = rd_ptr;
      while (idx != wr_ptr) begin
        if (ring[idx] == NEWLINE_CODE) begin
          stop = next_slot(idx);
          return 1'b1;
        end
        idx = next_slot(idx);
      end
      return 1'b0;
    endfunction

    function bit line_ready();
      int unsigned unused_stop;
      return find_newline(unused_stop);
    endfunction

    // Called once per accepted request.
    function void note_request(logic op, logic [7:0] data);
      result_t r;
      int unsigned idx;
      int unsigned stop;
      if (op == OP_PUSH) begin
        pushes++;
        r = '0;
        r.last_of_run = 1'b1;
        if (next_slot(wr_ptr) != rd_ptr) begin
          ring[wr_ptr] = data;
          wr_ptr = next_slot(wr_ptr);
          r.byte_stored = 1'b1;
        end else begin
          dropped++;
        end
        expected_results.push_back(r);
      end else begin
        takes++;
        if (!find_newline(stop)) begin
          r = '0;
          r.last_of_run = 1'b1;
          expected_results.push_back(r);
        end else begin
          lines_taken++;
          idx = rd_ptr;
          while (idx != stop) begin
            r = '0;
            r.line_found = 1'b1;
            r.line_byte = ring[idx];
            r.last_of_run = (next_slot(idx) == stop);
            expected_results.push_back(r);
            idx = next_slot(idx);
          end
          rd_ptr = stop;
        end
      end
    endfunction

    // Compares one accepted result with the oldest outstanding one.
    function void check_result(result_t got);
      result_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result: line_byte=%h byte_stored=%b line_found=%b last_of_run=%b",
               got.line_byte, got.byte_stored, got.line_found, got.last_of_run);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.byte_stored !== want.byte_stored) begin
        $error("byte_stored mismatch: expected %0d, actual %0d", want.byte_stored,
               got.byte_stored);
        errors++;
      end
      if (got.line_found !== want.line_found) begin
        $error("line_found mismatch: expected %0d, actual %0d", want.line_found,
               got.line_found);
        errors++;
      end
      if (got.line_byte !== want.line_byte) begin
        $error("line_byte mismatch: expected %h, actual %h", want.line_byte, got.line_byte);
        errors++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run mismatch: expected %0d, actual %0d", want.last_of_run,
               got.last_of_run);
        errors++;
      end
    endfunction
  endclass

  localparam int DEPTH          = 64;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 20;

  logic       clk;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tuser;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic       m_axis_tlast;

  line_ring_predictor sb;
  result_t observed;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_request;
  int hold_left;

  rx_line_ring_buffer #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off when asked for.
  initial begin
    m_axis_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Score every accepted result.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      observed.byte_stored = m_axis_tuser[0];
      observed.line_found  = m_axis_tuser[1];
      observed.line_byte   = m_axis_tdata;
      observed.last_of_run = m_axis_tlast;
      sb.check_result(observed);
    end
  end

  // End the run if neither side moves a request for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $error("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == NEWLINE_CODE);
    return b;
  endfunction

  function automatic logic [7:0] noise_byte();
    return ($urandom_range(0, 7) == 0) ? NEWLINE_CODE : 8'($urandom_range(0, 255));
  endfunction

  // Offers one request from a falling edge and returns at the falling edge after it
  // was accepted.
  task automatic send_request(input logic op, input logic [7:0] data);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(op, data);
    @(negedge clk);
  endtask

  task automatic push_byte(input logic [7:0] data);
    send_request(OP_PUSH, data);
  endtask

  task automatic take_line();
    send_request(OP_TAKE_LINE, 8'($urandom_range(0, 255)));
  endtask

  // Sender pauses until every outstanding result has been delivered.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk);
  endtask

  // Mostly complete lines with random text, plus noise, bare takes and bursts
  // of noise bytes. Occupancy is kept low enough that a newline always fits.
  task automatic run_random(input int n);
    int count;
    int kind;
    int len;
    int room;
    count = 0;
    while (count < n) begin
      kind = $urandom_range(0, 99);
      if (sb.stored_count() > 48) begin
        if (!sb.line_ready()) push_byte(NEWLINE_CODE);
        take_line();
        count++;
      end else if (kind < 55) begin
        room = 60 - sb.stored_count();
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 6);
        if (len > room) len = room;
        for (int i = 0; i < len; i++) push_byte(text_byte());
        push_byte(NEWLINE_CODE);
        take_line();
        count += len + 2;
      end else if (kind < 70) begin
        take_line();
        count++;
      end else if (kind < 88) begin
        send_request(1'($urandom_range(0, 1)), noise_byte());
        count++;
      end else begin
        room = 52 - sb.stored_count();
        len = $urandom_range(4, 16);
        if (len > room) len = room;
        for (int i = 0; i < len; i++) push_byte(noise_byte());
        count += len;
      end
    end
  endtask

  // Empties the ring, then fills it to the brim while the receiver holds off,
  // pushes into the full ring and takes the longest possible line.
  task automatic fill_ring_under_backpressure();
    if (sb.stored_count() != 0) begin
      push_byte(NEWLINE_CODE);
      while (sb.line_ready()) take_line();
    end
    hold_request = 1'b1;
    for (int i = 0; i < DEPTH - 2; i++) push_byte(text_byte());
    push_byte(NEWLINE_CODE);
    for (int i = 0; i < 3; i++) push_byte(noise_byte());
    take_line();
  endtask

  // Stimulus and final report.
  initial begin
    sb = new(DEPTH);
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_PUSH;
    hold_request = 1'b0;
    send_idle_pct = 31;
    recv_idle_pct = 76;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty ring, byte extremes, no newline yet, short lines, and a
    // take whose data bits are all set.
    take_line();
    push_byte(8'h00);
    push_byte(8'hFF);
    send_request(OP_TAKE_LINE, 8'hFF);
    push_byte(NEWLINE_CODE);
    send_request(OP_TAKE_LINE, 8'h00);
    take_line();
    push_byte(NEWLINE_CODE);
    take_line();
    push_byte(8'h55);
    push_byte(8'hAA);
    push_byte(NEWLINE_CODE);
    push_byte(8'h33);
    push_byte(NEWLINE_CODE);
    take_line();
    take_line();
    take_line();

    // Phase one: sender idles a little, receiver a lot.
    run_random(35);
    fill_ring_under_backpressure();
    wait_drained();

    // Phase two: the other way round.
    send_idle_pct = 76;
    recv_idle_pct = 31;
    run_random(40);
    wait_drained();

    // Phase three: no idling at all.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(40);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.expected_results.size() != 0) begin
      $error("%0d results never arrived", sb.expected_results.size());
      sb.errors++;
    end

    $display("Run covered %0d pushes (%0d dropped on a full ring) and %0d take-line requests.",
             sb.pushes, sb.dropped, sb.takes);
    $display("%0d results checked, %0d complete lines extracted, %0d mismatches.",
             sb.results_seen, sb.lines_taken, sb.errors);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
